// ===== rtl/core/link_handshake_sync_fsm_core_assert.svh =====
// assertion macros for the link handshake sync core checker
`ifndef LINK_HANDSHAKE_SYNC_FSM_CORE_ASSERT_SVH
`define LINK_HANDSHAKE_SYNC_FSM_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LHSF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LHSF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lhsf_pkg.sv =====
// types and constants for the link handshake sync core
package lhsf_pkg;

    localparam int unsigned AGE_W = 16;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [AGE_W-1:0] AGE_MAX = '1;
    localparam logic [AGE_W-1:0] RETRY_RESET = 16'd1000;
    localparam logic [AGE_W-1:0] TIMEOUT_RESET = 16'd5000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BOOT_RETRY  = 1'b0,
        CFG_STATE_TMOUT = 1'b1
    } lhsf_cfg_t;

    typedef enum logic [2:0] {
        MODE_START   = 3'd0,
        MODE_RESYNC  = 3'd1,
        MODE_TICK    = 3'd2,
        MODE_DETAILS = 3'd3,
        MODE_STATE   = 3'd4
    } lhsf_mode_t;

    typedef enum logic [1:0] {
        PH_DETAILS = 2'd0,
        PH_STATE   = 2'd1,
        PH_SYNCED  = 2'd2
    } lhsf_phase_t;

    typedef struct packed {
        logic [2:0]       mode;
        logic [AGE_W-1:0] delta_ms;
        logic             boot_accepted;
    } lhsf_in_t;

    typedef struct packed {
        logic       send_boot;
        logic       send_ping;
        logic       allow_state_requests;
        logic       allow_mutating;
        logic [1:0] phase;
    } lhsf_out_t;

endpackage

// ===== rtl/core/link_handshake_sync_fsm_core.sv =====
// link handshake sync core: controller-side three-phase handshake tracker
//
// s_valid/s_ready/s_data carry one event request per beat (start, resync,
// tick with elapsed ms, details served, state served). m_valid/m_ready/m_data
// return exactly one result per event: boot and ping requests, trust gates
// and the phase after the event.
// cfg_we/cfg_addr/cfg_wdata write the boot retry interval (index 0) and the
// await-state timeout (index 1) at any edge with cfg_we high.
// An event is taken into an input register, evaluated against the phase and
// the two saturating ages, and lands in an output register when it is free:
// the result is then on m_data and can be taken at the next edge; one event
// per cycle is sustained while the receiver does not stall.
// A stalled receiver holds the output register; the input register still
// takes one more event, after which s_ready follows m_ready.
// Synchronous active-low reset empties both registers and sets phase to
// awaiting details, boot age to 65535, await age to 0 and config to 1000/5000.
module link_handshake_sync_fsm_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  lhsf_pkg::lhsf_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output lhsf_pkg::lhsf_out_t             m_data,
    input  logic                            cfg_we,
    input  logic [lhsf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lhsf_pkg::AGE_W-1:0]      cfg_wdata
);
    import lhsf_pkg::*;

    logic             in_valid_reg;
    lhsf_in_t         in_reg;
    logic             out_valid_reg;
    lhsf_out_t        out_reg;
    lhsf_phase_t      phase_reg, phase_next;
    logic [AGE_W-1:0] boot_age_reg, boot_age_next;
    logic [AGE_W-1:0] await_age_reg, await_age_next;
    logic [AGE_W-1:0] retry_ms_reg, timeout_ms_reg;
    lhsf_out_t        result_next;
    logic [AGE_W:0]   boot_sum, await_sum;
    logic [AGE_W-1:0] boot_tick, await_tick;
    logic             out_free, in_fire, s_fire;

    assign out_free = !out_valid_reg || m_ready;
    assign in_fire  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_ms_reg   <= RETRY_RESET;
            timeout_ms_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            case (lhsf_cfg_t'(cfg_addr))
                CFG_BOOT_RETRY:  retry_ms_reg   <= cfg_wdata;
                CFG_STATE_TMOUT: timeout_ms_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_fire) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_DETAILS;
            boot_age_reg  <= AGE_MAX;
            await_age_reg <= '0;
        end else if (in_fire) begin
            phase_reg     <= phase_next;
            boot_age_reg  <= boot_age_next;
            await_age_reg <= await_age_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
        if (in_fire) begin
            out_reg <= result_next;
        end
    end

    always_comb begin
        boot_sum   = {1'b0, boot_age_reg} + {1'b0, in_reg.delta_ms};
        await_sum  = {1'b0, await_age_reg} + {1'b0, in_reg.delta_ms};
        boot_tick  = boot_sum[AGE_W] ? AGE_MAX : boot_sum[AGE_W-1:0];
        await_tick = await_sum[AGE_W] ? AGE_MAX : await_sum[AGE_W-1:0];

        phase_next     = phase_reg;
        boot_age_next  = boot_age_reg;
        await_age_next = await_age_reg;
        result_next    = '0;

        case (lhsf_mode_t'(in_reg.mode))
            MODE_START: begin
                phase_next            = PH_DETAILS;
                await_age_next        = '0;
                boot_age_next         = in_reg.boot_accepted ? '0 : AGE_MAX;
                result_next.send_boot = 1'b1;
            end
            MODE_RESYNC: begin
                phase_next     = PH_DETAILS;
                await_age_next = '0;
                boot_age_next  = '0;
            end
            MODE_TICK: begin
                boot_age_next  = boot_tick;
                await_age_next = await_tick;
                case (phase_reg)
                    PH_SYNCED: begin
                        result_next.send_ping = 1'b1;
                    end
                    PH_DETAILS: begin
                        if (boot_tick >= retry_ms_reg) begin
                            result_next.send_boot = 1'b1;
                            if (in_reg.boot_accepted) begin
                                boot_age_next = '0;
                            end
                        end
                    end
                    PH_STATE: begin
                        if (await_tick >= timeout_ms_reg) begin
                            phase_next            = PH_DETAILS;
                            await_age_next        = '0;
                            boot_age_next         = in_reg.boot_accepted ? '0 : AGE_MAX;
                            result_next.send_boot = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_DETAILS: begin
                if (phase_reg == PH_DETAILS) begin
                    phase_next     = PH_STATE;
                    await_age_next = '0;
                end
            end
            MODE_STATE: begin
                if (phase_reg == PH_STATE) begin
                    phase_next     = PH_SYNCED;
                    await_age_next = '0;
                end
            end
            default: ;
        endcase

        result_next.allow_state_requests = (phase_next != PH_DETAILS);
        result_next.allow_mutating       = (phase_next == PH_SYNCED);
        result_next.phase                = phase_next;
    end

endmodule

// ===== rtl/core/lhsf_checker.sv =====
// port-level checker for the link handshake sync core, with its bind
`include "link_handshake_sync_fsm_core_assert.svh"

module lhsf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input lhsf_pkg::lhsf_in_t              s_data,
    input logic                            m_valid,
    input logic                            m_ready,
    input lhsf_pkg::lhsf_out_t             m_data,
    input logic                            cfg_we,
    input logic [lhsf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input logic [lhsf_pkg::AGE_W-1:0]      cfg_wdata
);
    import lhsf_pkg::*;

    logic gates_ok;
    logic unused_ok;
    logic ping_seen;
    logic ping_ok;
    logic boot_seen;
    logic boot_ok;
    logic stalled;

    assign unused_ok = s_valid || s_ready || (|s_data) || cfg_we || (|cfg_addr)
                    || (|cfg_wdata) || 1'b1;
    assign gates_ok = (m_data.allow_state_requests == (m_data.phase != PH_DETAILS))
                   && (m_data.allow_mutating == (m_data.phase == PH_SYNCED))
                   && (m_data.phase != 2'd3) && unused_ok;
    assign ping_seen = m_valid && m_data.send_ping;
    assign ping_ok   = m_data.allow_mutating && !m_data.send_boot;
    assign boot_seen = m_valid && m_data.send_boot;
    assign boot_ok   = (m_data.phase == PH_DETAILS);
    assign stalled   = m_valid && !m_ready;

    `LHSF_ASSERT_NOW(a_gates_match, aclk, aresetn, m_valid, gates_ok, "gates disagree with phase")
    `LHSF_ASSERT_NOW(a_ping_only_synced, aclk, aresetn, ping_seen, ping_ok, "ping outside synced")
    `LHSF_ASSERT_NOW(a_boot_ends_details, aclk, aresetn, boot_seen, boot_ok, "boot outside details")
    `LHSF_ASSERT_NEXT(a_stall_keeps, aclk, aresetn, stalled, m_valid, "valid dropped in stall")
    `LHSF_ASSERT_NEXT(a_stall_holds, aclk, aresetn, stalled, $stable(m_data), "data changed in stall")

endmodule

bind link_handshake_sync_fsm_core lhsf_checker u_lhsf_checker (.*);

// ===== bench/link_handshake_sync_fsm_core_check.sv =====
// checker for the link handshake sync core: event predictor and result compare
`timescale 1ns / 1ps

module link_handshake_sync_fsm_core_check
    import lhsf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  lhsf_in_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  lhsf_out_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [AGE_W-1:0]      cfg_wdata,
    output int unsigned           failures,
    output int unsigned           outstanding
);

    lhsf_phase_t      link_phase;
    logic [AGE_W-1:0] boot_age_ms;
    logic [AGE_W-1:0] await_age_ms;
    logic [AGE_W-1:0] retry_ms;
    logic [AGE_W-1:0] timeout_ms;
    lhsf_out_t        link_outcomes_q[$];
    int unsigned      fail_tally;

    function automatic logic [AGE_W-1:0] sat_age(input logic [AGE_W-1:0] a,
                                                 input logic [AGE_W-1:0] b);
        logic [AGE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[AGE_W] ? AGE_MAX : sum[AGE_W-1:0];
    endfunction

    function automatic lhsf_out_t advance_link(input lhsf_in_t ev);
        lhsf_out_t r;
        r = '0;
        case (ev.mode)
            MODE_START: begin
                link_phase = PH_DETAILS;
                await_age_ms = '0;
                boot_age_ms = ev.boot_accepted ? '0 : AGE_MAX;
                r.send_boot = 1'b1;
            end
            MODE_RESYNC: begin
                link_phase = PH_DETAILS;
                await_age_ms = '0;
                boot_age_ms = '0;
            end
            MODE_TICK: begin
                boot_age_ms = sat_age(boot_age_ms, ev.delta_ms);
                await_age_ms = sat_age(await_age_ms, ev.delta_ms);
                case (link_phase)
                    PH_SYNCED: r.send_ping = 1'b1;
                    PH_DETAILS: begin
                        if (boot_age_ms >= retry_ms) begin
                            r.send_boot = 1'b1;
                            if (ev.boot_accepted) boot_age_ms = '0;
                        end
                    end
                    PH_STATE: begin
                        if (await_age_ms >= timeout_ms) begin
                            // state timeout falls back and re-announces
                            link_phase = PH_DETAILS;
                            await_age_ms = '0;
                            boot_age_ms = ev.boot_accepted ? '0 : AGE_MAX;
                            r.send_boot = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_DETAILS: begin
                if (link_phase == PH_DETAILS) begin
                    link_phase = PH_STATE;
                    await_age_ms = '0;
                end
            end
            MODE_STATE: begin
                if (link_phase == PH_STATE) begin
                    link_phase = PH_SYNCED;
                    await_age_ms = '0;
                end
            end
            default: ;
        endcase
        r.allow_state_requests = (link_phase != PH_DETAILS);
        r.allow_mutating = (link_phase == PH_SYNCED);
        r.phase = link_phase;
        return r;
    endfunction

    task automatic report_field(input string name, input logic [1:0] want,
                                input logic [1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge aclk) begin
        lhsf_out_t want;
        if (!aresetn) begin
            link_phase = PH_DETAILS;
            boot_age_ms = AGE_MAX;
            await_age_ms = '0;
            retry_ms = RETRY_RESET;
            timeout_ms = TIMEOUT_RESET;
            link_outcomes_q.delete();
            fail_tally = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_BOOT_RETRY: retry_ms = cfg_wdata;
                    CFG_STATE_TMOUT: timeout_ms = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (link_outcomes_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_data);
                    fail_tally++;
                end else begin
                    want = link_outcomes_q.pop_front();
                    report_field("send_boot", want.send_boot, m_data.send_boot);
                    report_field("send_ping", want.send_ping, m_data.send_ping);
                    report_field("allow_state_requests", want.allow_state_requests,
                                 m_data.allow_state_requests);
                    report_field("allow_mutating", want.allow_mutating,
                                 m_data.allow_mutating);
                    report_field("phase", want.phase, m_data.phase);
                end
            end
            if (s_valid && s_ready) link_outcomes_q.push_back(advance_link(s_data));
        end
        failures <= fail_tally;
        outstanding <= link_outcomes_q.size();
    end

endmodule

// ===== bench/link_handshake_sync_fsm_core_test.sv =====
// testbench top for the link handshake sync core: stimulus, stalls and verdict
`timescale 1ns / 1ps

module link_handshake_sync_fsm_core_test;
    import lhsf_pkg::*;

    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned SEGMENTS = 6;
    localparam int unsigned SEGMENT_ITEMS = 275;
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    lhsf_in_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    lhsf_out_t             m_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [AGE_W-1:0]      cfg_wdata = '0;

    int unsigned      failures;
    int unsigned      outstanding;
    int unsigned      send_idle_pct = 32;
    int unsigned      recv_stall_pct = 63;
    int unsigned      quiet_cycles = 0;
    logic [AGE_W-1:0] retry_cfg = RETRY_RESET;
    logic [AGE_W-1:0] timeout_cfg = TIMEOUT_RESET;

    link_handshake_sync_fsm_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    link_handshake_sync_fsm_core_check checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("link_handshake_sync_fsm_core_test NOT OK");
            $finish;
        end
    end

    function automatic lhsf_in_t make_ev(input logic [2:0] mode,
                                         input logic [AGE_W-1:0] elapsed,
                                         input logic accepted);
        lhsf_in_t ev;
        ev.mode = mode;
        ev.delta_ms = elapsed;
        ev.boot_accepted = accepted;
        return ev;
    endfunction

    // mostly ticks sized against the current interval, with enough
    // details and state requests to walk the phases
    function automatic lhsf_in_t draw_link_event();
        lhsf_in_t         ev;
        int unsigned      pick;
        logic [AGE_W-1:0] span;
        ev.delta_ms = AGE_W'($urandom_range(65535, 0));
        ev.boot_accepted = ($urandom_range(99) < 65);
        pick = $urandom_range(99);
        if (pick < 6) begin
            ev.mode = MODE_START;
        end else if (pick < 10) begin
            ev.mode = MODE_RESYNC;
        end else if (pick < 62) begin
            ev.mode = MODE_TICK;
            span = $urandom_range(1) ? retry_cfg : timeout_cfg;
            pick = $urandom_range(99);
            if (pick < 15) begin
                ev.delta_ms = AGE_W'($urandom_range(3, 0));
            end else if (pick < 60) begin
                ev.delta_ms = AGE_W'($urandom_range(span, 0));
            end else if (pick < 70) begin
                ev.delta_ms = AGE_MAX;
            end
        end else if (pick < 78) begin
            ev.mode = MODE_DETAILS;
        end else if (pick < 96) begin
            ev.mode = MODE_STATE;
        end else begin
            ev.mode = 3'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
        end
        return ev;
    endfunction

    task automatic push_event(input lhsf_in_t ev);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data <= ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic settle_link();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [AGE_W-1:0] retry,
                              input logic [AGE_W-1:0] timeout);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_BOOT_RETRY;
        cfg_wdata <= retry;
        @(posedge aclk);
        cfg_addr <= CFG_STATE_TMOUT;
        cfg_wdata <= timeout;
        @(posedge aclk);
        cfg_we <= 1'b0;
        retry_cfg = retry;
        timeout_cfg = timeout;
    endtask

    initial begin
        int unsigned seg;
        int unsigned n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed walk through the phases with reset intervals
        push_event(make_ev(MODE_TICK, 16'd0, 1'b0));
        push_event(make_ev(MODE_TICK, 16'd0, 1'b1));
        push_event(make_ev(MODE_TICK, 16'd999, 1'b1));
        push_event(make_ev(MODE_TICK, 16'd1, 1'b0));
        push_event(make_ev(MODE_STATE, 16'hffff, 1'b1));
        push_event(make_ev(MODE_DETAILS, 16'h5a5a, 1'b0));
        push_event(make_ev(MODE_DETAILS, 16'ha5a5, 1'b1));
        push_event(make_ev(MODE_TICK, 16'd4999, 1'b1));
        push_event(make_ev(MODE_TICK, 16'd1, 1'b1));
        push_event(make_ev(MODE_DETAILS, 16'd0, 1'b0));
        push_event(make_ev(MODE_STATE, 16'd0, 1'b0));
        push_event(make_ev(MODE_TICK, 16'hffff, 1'b1));
        push_event(make_ev(MODE_TICK, 16'd0, 1'b0));
        push_event(make_ev(MODE_STATE, 16'd7, 1'b1));
        push_event(make_ev(MODE_DETAILS, 16'd7, 1'b1));
        push_event(make_ev(MODE_UNUSED_LO, 16'hffff, 1'b1));
        push_event(make_ev(MODE_UNUSED_MID, 16'h1234, 1'b0));
        push_event(make_ev(MODE_UNUSED_HI, 16'h0000, 1'b1));
        push_event(make_ev(MODE_RESYNC, 16'hffff, 1'b1));
        push_event(make_ev(MODE_TICK, 16'hffff, 1'b0));
        push_event(make_ev(MODE_START, 16'd0, 1'b0));
        push_event(make_ev(MODE_START, 16'hffff, 1'b1));
        push_event(make_ev(MODE_DETAILS, 16'd0, 1'b1));
        push_event(make_ev(MODE_TICK, 16'hffff, 1'b0));

        for (seg = 0; seg < SEGMENTS; seg++) begin
            settle_link();
            if (seg < 2) begin
                send_idle_pct = 32;
                recv_stall_pct = 63;
            end else if (seg < 4) begin
                send_idle_pct = 63;
                recv_stall_pct = 32;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            case (seg)
                0: set_config(16'd1, 16'd1);
                1: set_config(16'hffff, 16'hffff);
                2: set_config(AGE_W'($urandom_range(3000, 1)),
                              AGE_W'($urandom_range(8000, 1)));
                3: set_config(RETRY_RESET, TIMEOUT_RESET);
                4: set_config(16'hffff, 16'd1);
                default: set_config(16'd1, 16'hffff);
            endcase
            for (n = 0; n < SEGMENT_ITEMS; n++) begin
                push_event(draw_link_event());
            end
        end
        settle_link();

        if (failures == 0 && outstanding == 0) begin
            $display("link_handshake_sync_fsm_core_test OK");
        end else begin
            $display("link_handshake_sync_fsm_core_test NOT OK");
        end
        $finish;
    end

endmodule
